FILE: rtl/eft_pkg.sv
package eft_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int TIME_BITS   = 48;
  localparam int COUNT_BITS  = $clog2(TABLE_DEPTH + 1);
  localparam int OUT_COUNT_BITS = 7;

  localparam logic OP_QUERY  = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  localparam logic ST_OK   = 1'b0;
  localparam logic ST_FULL = 1'b1;

  typedef logic [TIME_BITS-1:0] time_t;

  // one stored busy interval
  typedef struct packed {
    logic  valid;
    time_t start;
    time_t finish;
  } entry_t;

  // insert request broadcast to every cell
  typedef struct packed {
    logic  go;
    time_t start;
    time_t finish;
  } ins_t;

  // query beat travelling down the chain
  typedef struct packed {
    logic  tok;
    logic  found;
    time_t cand;
    time_t need;
  } walk_t;

endpackage

FILE: rtl/eft_cell.sv
module eft_cell
  import eft_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  ins_t   ins,
  input  entry_t left_ent,
  input  logic   left_lt,
  input  walk_t  walk_in,
  output entry_t ent,
  output logic   lt,
  output walk_t  walk_out
);

  entry_t ent_next;
  walk_t  walk_next;
  time_t  gap;
  logic   cand_le;
  logic   fits;

  // entries below the insert point stay, the first one at or above it takes
  // the new pair, the rest shift one place right
  assign lt = ent.valid && (ent.start < ins.start);

  always_comb begin
    ent_next = ent;
    if (ins.go && !lt) begin
      if (left_lt) begin
        ent_next.valid  = 1'b1;
        ent_next.start  = ins.start;
        ent_next.finish = ins.finish;
      end else begin
        ent_next = left_ent;
      end
    end
  end

  assign cand_le = walk_in.cand <= ent.start;
  assign gap     = ent.start - walk_in.cand;
  assign fits    = cand_le && (walk_in.need <= gap);

  always_comb begin
    walk_next = walk_in;
    if (ent.valid && !walk_in.found) begin
      if (fits) begin
        walk_next.found = 1'b1;
      end else if (walk_in.cand < ent.finish) begin
        walk_next.cand = ent.finish;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent.valid    <= 1'b0;
      walk_out.tok <= 1'b0;
    end else begin
      ent.valid    <= ent_next.valid;
      walk_out.tok <= walk_in.tok;
    end
    ent.start          <= ent_next.start;
    ent.finish         <= ent_next.finish;
    walk_out.found     <= walk_next.found;
    walk_out.cand      <= walk_next.cand;
    walk_out.need      <= walk_next.need;
  end

endmodule

FILE: rtl/earliest_fit_interval_table.sv
// Reservation table for one resource: up to TABLE_DEPTH busy intervals kept
// sorted by start in a row of cells, one interval per cell. An insert beat
// (operation = 1) is placed with all cells shifting at once, and its result
// is parked in a pending register before it moves to the output register;
// into a full table it is dropped with status = 1 (ST_FULL). A query beat
// (operation = 0) travels down the row one cell per cycle, through every
// cell whatever the fill level. One beat is in work at a time; the next is
// taken once the previous result sits in the output register, which holds it
// until out_stall drops. entry_count reports the fill level after each beat.
module earliest_fit_interval_table
  import eft_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      operation,
  input  logic [TIME_BITS-1:0]      ready_time,
  input  logic [TIME_BITS-1:0]      duration,
  input  logic [TIME_BITS-1:0]      insert_start,
  input  logic [TIME_BITS-1:0]      insert_finish,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [TIME_BITS-1:0]      slot_start,
  output logic                      status,
  output logic [OUT_COUNT_BITS-1:0] entry_count
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WALK = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]            state;
  logic [1:0]            state_next;
  logic [COUNT_BITS-1:0] count;
  logic                  accept;
  logic                  full;
  logic                  out_load;
  ins_t                  ins;
  walk_t                 launch;
  time_t                 res_slot;
  logic                  res_status;
  logic [COUNT_BITS-1:0] res_count;

  entry_t                ents  [TABLE_DEPTH];
  logic                  lts   [TABLE_DEPTH];
  walk_t                 walks [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] toks;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign full     = (count == COUNT_BITS'(TABLE_DEPTH));

  assign ins.go     = accept && (operation == OP_INSERT) && !full;
  assign ins.start  = insert_start;
  assign ins.finish = insert_finish;

  assign launch.tok   = accept && (operation == OP_QUERY);
  assign launch.found = 1'b0;
  assign launch.cand  = ready_time;
  assign launch.need  = duration;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      eft_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .ins      (ins),
        .left_ent ('0),
        .left_lt  (1'b1),
        .walk_in  (launch),
        .ent      (ents[i]),
        .lt       (lts[i]),
        .walk_out (walks[i])
      );
    end else begin : g_body
      eft_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .ins      (ins),
        .left_ent (ents[i-1]),
        .left_lt  (lts[i-1]),
        .walk_in  (walks[i-1]),
        .ent      (ents[i]),
        .lt       (lts[i]),
        .walk_out (walks[i])
      );
    end
    assign toks[i] = walks[i].tok;
  end

  assign out_load = (state == S_DONE) && (!out_valid || !out_stall);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = (operation == OP_INSERT) ? S_DONE : S_WALK;
        end
      end
      S_WALK: begin
        if (toks[TABLE_DEPTH-1]) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ins.go) begin
        count <= count + COUNT_BITS'(1);
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // pending result, parked until the output register is free
  always_ff @(posedge clk) begin
    if (accept && (operation == OP_INSERT)) begin
      res_slot   <= '0;
      res_status <= full ? ST_FULL : ST_OK;
      res_count  <= full ? count : count + COUNT_BITS'(1);
    end else if ((state == S_WALK) && toks[TABLE_DEPTH-1]) begin
      res_slot   <= walks[TABLE_DEPTH-1].cand;
      res_status <= ST_OK;
      res_count  <= count;
    end
    if (out_load) begin
      slot_start  <= res_slot;
      status      <= res_status;
      entry_count <= OUT_COUNT_BITS'(res_count);
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_BITS'(TABLE_DEPTH))
    else $error("fill count beyond table depth");

  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $onehot0(toks))
    else $error("more than one query in the cell row");

  a_idle_no_token: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (toks == '0))
    else $error("query in flight while idle");

  a_insert_count: assert property (@(posedge clk) disable iff (rst)
    ins.go |=> (count == $past(count) + COUNT_BITS'(1)))
    else $error("insert did not bump fill count");

  a_full_drop: assert property (@(posedge clk) disable iff (rst)
    (accept && (operation == OP_INSERT) && full) |=> $stable(count))
    else $error("insert into full table changed fill count");
`endif

endmodule

FILE: tb/sv/earliest_fit_interval_table_tb.sv
module earliest_fit_interval_table_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import eft_pkg::*;

  localparam int    HALF_PERIOD  = 5;
  localparam int    RANDOM_BEATS = 1950;
  localparam int    QUIET_LIMIT  = 2000;
  localparam time_t TIME_MAX     = '1;

  typedef struct {
    logic  op;
    time_t ready;
    time_t need;
    time_t ins_start;
    time_t ins_finish;
  } request_t;

  typedef struct {
    time_t                     slot;
    logic                      flag;
    logic [OUT_COUNT_BITS-1:0] count;
  } slot_report_t;

  logic                      clk           = 1'b0;
  logic                      rst           = 1'b1;
  logic                      in_valid      = 1'b0;
  logic                      in_stall;
  logic                      operation     = OP_QUERY;
  time_t                     ready_time    = '0;
  time_t                     duration      = '0;
  time_t                     insert_start  = '0;
  time_t                     insert_finish = '0;
  logic                      out_valid;
  logic                      out_stall     = 1'b0;
  time_t                     slot_start;
  logic                      status;
  logic [OUT_COUNT_BITS-1:0] entry_count;

  // shadow copy of the reservation table
  time_t sched_start  [TABLE_DEPTH];
  time_t sched_finish [TABLE_DEPTH];
  int    sched_count = 0;

  request_t     pending_requests[$];
  slot_report_t awaited_reports[$];

  int          beats_total  = 0;
  int          beats_taken  = 0;
  int          mismatches   = 0;
  int          quiet_cycles = 0;
  logic        in_accepted  = 1'b0;
  logic        out_accepted = 1'b0;
  logic        in_calm      = 1'b0;
  logic        out_calm     = 1'b0;
  int unsigned in_wait      = 0;
  int unsigned out_hold     = 0;

  earliest_fit_interval_table u_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .operation     (operation),
    .ready_time    (ready_time),
    .duration      (duration),
    .insert_start  (insert_start),
    .insert_finish (insert_finish),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .slot_start    (slot_start),
    .status        (status),
    .entry_count   (entry_count)
  );

  always #HALF_PERIOD clk = ~clk;

  function automatic time_t any_time();
    return time_t'({$urandom(), $urandom()});
  endfunction

  function automatic int unsigned pause_len(logic calm);
    return calm ? 0 : $urandom_range(0, 14);
  endfunction

  function automatic void stage_request(request_t r);
    pending_requests.insert(pending_requests.size(), r);
  endfunction

  // unused fields carry noise so the block is seen to ignore them
  function automatic request_t query_beat(time_t r, time_t d);
    request_t q;
    q.op = OP_QUERY;
    q.ready = r;
    q.need = d;
    q.ins_start = any_time();
    q.ins_finish = any_time();
    return q;
  endfunction

  function automatic request_t insert_beat(time_t s, time_t f);
    request_t q;
    q.op = OP_INSERT;
    q.ready = any_time();
    q.need = any_time();
    q.ins_start = s;
    q.ins_finish = f;
    return q;
  endfunction

  function automatic request_t random_query();
    time_t r, d;
    case ($urandom_range(0, 15))
      0: r = '0;
      1: r = TIME_MAX;
      2: r = any_time();
      default: r = time_t'($urandom_range(0, 210000));
    endcase
    case ($urandom_range(0, 15)) inside
      [0:1]: d = '0;
      2: d = TIME_MAX;
      3: d = any_time();
      [4:5]: d = time_t'($urandom_range(0, 60000));
      default: d = time_t'($urandom_range(1, 3000));
    endcase
    return query_beat(r, d);
  endfunction

  function automatic request_t random_insert();
    time_t s, f;
    case ($urandom_range(0, 15)) inside
      0: begin
        s = any_time();
        f = any_time();
      end
      1: begin
        s = time_t'($urandom_range(1000, 200000));
        f = s - time_t'($urandom_range(1, 1000));
      end
      2: begin
        s = time_t'(1000 * $urandom_range(0, 200));
        f = s;
      end
      // coarse grid so equal starts turn up
      [3:5]: begin
        s = time_t'(1000 * $urandom_range(0, 200));
        f = s + time_t'($urandom_range(1, 3000));
      end
      default: begin
        s = time_t'($urandom_range(0, 200000));
        f = s + time_t'($urandom_range(1, 3000));
      end
    endcase
    return insert_beat(s, f);
  endfunction

  function automatic time_t earliest_slot(time_t ready, time_t need);
    time_t cand;
    cand = ready;
    for (int i = 0; i < sched_count; i++) begin
      if (cand <= sched_start[i] && need <= sched_start[i] - cand)
        return cand;
      if (cand < sched_finish[i])
        cand = sched_finish[i];
    end
    return cand;
  endfunction

  function automatic logic reserve_interval(time_t s, time_t f);
    int pos;
    if (sched_count >= TABLE_DEPTH)
      return ST_FULL;
    pos = 0;
    while (pos < sched_count && sched_start[pos] < s)
      pos++;
    for (int k = sched_count; k > pos; k--) begin
      sched_start[k]  = sched_start[k-1];
      sched_finish[k] = sched_finish[k-1];
    end
    sched_start[pos]  = s;
    sched_finish[pos] = f;
    sched_count++;
    return ST_OK;
  endfunction

  // sender: one beat at a time, random gap after each acceptance
  always @(negedge clk) begin
    request_t beat;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_accepted) begin
      if (in_wait != 0) begin
        in_valid <= 1'b0;
        in_wait  <= in_wait - 1;
      end else if (pending_requests.size() != 0) begin
        beat = pending_requests.pop_front();
        operation     <= beat.op;
        ready_time    <= beat.ready;
        duration      <= beat.need;
        insert_start  <= beat.ins_start;
        insert_finish <= beat.ins_finish;
        in_valid      <= 1'b1;
        in_wait       <= pause_len(in_calm);
        if ($urandom_range(0, 39) == 0)
          in_calm <= ~in_calm;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: hold-off counts only cycles with a result waiting
  always @(negedge clk) begin
    int unsigned left;
    if (rst) begin
      out_stall <= 1'b0;
      out_hold  <= 0;
    end else begin
      left = out_accepted ? pause_len(out_calm) : out_hold;
      out_stall <= (left != 0);
      out_hold  <= (left != 0 && out_valid) ? left - 1 : left;
      if (out_accepted && $urandom_range(0, 39) == 0)
        out_calm <= ~out_calm;
    end
  end

  always @(posedge clk) begin
    slot_report_t want, next;
    if (rst) begin
      in_accepted  <= 1'b0;
      out_accepted <= 1'b0;
      quiet_cycles <= 0;
      sched_count = 0;
    end else begin
      in_accepted  <= in_valid && !in_stall;
      out_accepted <= out_valid && !out_stall;

      // check before predicting so a stray result never meets this beat's entry
      if (out_valid && !out_stall) begin
        if (awaited_reports.size() == 0) begin
          $error("unexpected result: slot_start %0h status %0b entry_count %0d",
                 slot_start, status, entry_count);
          mismatches++;
        end else begin
          want = awaited_reports.pop_front();
          if (slot_start !== want.slot) begin
            $error("slot_start: expected %0h, got %0h", want.slot, slot_start);
            mismatches++;
          end
          if (status !== want.flag) begin
            $error("status: expected %0b, got %0b", want.flag, status);
            mismatches++;
          end
          if (entry_count !== want.count) begin
            $error("entry_count: expected %0d, got %0d", want.count, entry_count);
            mismatches++;
          end
        end
      end

      if (in_valid && !in_stall) begin
        next.slot = '0;
        next.flag = ST_OK;
        if (operation == OP_QUERY)
          next.slot = earliest_slot(ready_time, duration);
        else
          next.flag = reserve_interval(insert_start, insert_finish);
        next.count = OUT_COUNT_BITS'(sched_count);
        awaited_reports.insert(awaited_reports.size(), next);
        beats_taken <= beats_taken + 1;
      end

      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    // empty table
    stage_request(query_beat('0, '0));
    stage_request(query_beat(TIME_MAX, TIME_MAX));
    // (50,80) (100,150) (100,200) (300,250): equal start lands in front
    stage_request(insert_beat(100, 200));
    stage_request(insert_beat(50, 80));
    stage_request(insert_beat(100, 150));
    stage_request(insert_beat(300, 250));
    stage_request(query_beat(0, 50));
    stage_request(query_beat(0, 51));
    stage_request(query_beat(0, 0));
    stage_request(query_beat(60, 0));
    stage_request(query_beat(250, 100));
    stage_request(query_beat(TIME_MAX, 0));
    stage_request(query_beat(0, TIME_MAX));
    stage_request(insert_beat('0, TIME_MAX));
    stage_request(insert_beat(TIME_MAX, TIME_MAX));
    stage_request(query_beat(0, 1));
    stage_request(insert_beat('0, '0));
    stage_request(query_beat('0, '0));
    stage_request(query_beat(any_time(), any_time()));

    // sparse inserts: the table fills part way through, then drops follow
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      if ($urandom_range(0, 9) == 0)
        stage_request(random_insert());
      else
        stage_request(random_query());
    end
    beats_total = pending_requests.size();

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (beats_taken < beats_total)
      @(negedge clk);
    while (awaited_reports.size() != 0)
      @(negedge clk);
    repeat (TABLE_DEPTH + 16) @(negedge clk);

    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
